// ===== rtl/iafp_pkg.sv =====
// Shared types and constants for the attitude frame parser.
// No dependencies; the scanner and the top-level unit import this package.
`default_nettype none

package iafp_pkg;

	localparam int FRAME_BYTES     = 11;
	localparam int CHECK_POS       = FRAME_BYTES - 1;
	localparam int FILL_W          = 4;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 8;
	localparam int BYTE_QUEUE_DEF  = 2;
	localparam int RESULT_QUEUE_DEF = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTITUDE_TYPE = 2'd1;

	localparam logic [7:0] START_BYTE_RST    = 8'h55;
	localparam logic [7:0] ATTITUDE_TYPE_RST = 8'h53;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

	typedef struct packed {
		logic              busy;
		logic [FILL_W-1:0] fill;
	} scan_stat_t;

endpackage

`default_nettype wire

// ===== rtl/iafp_fifo.sv =====
// Small first-in first-out queue used on both sides of the frame scanner.
// Depends on nothing but its parameters.
`default_nettype none

module iafp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iafp_scanner.sv =====
// Back end: frame store, header scan, running checksum and result emit.
// Also holds the two configuration registers. Uses iafp_pkg.
`default_nettype none

module iafp_scanner (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic [7:0]                          in_byte,
	output logic                                     in_take,
	input  wire logic                                out_full,
	output logic                                     out_push,
	output iafp_pkg::result_t                        out_data,
	input  wire logic                                wr_en,
	input  wire logic [iafp_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  wire logic [iafp_pkg::CFG_DATA_W-1:0]     wr_data,
	output iafp_pkg::scan_stat_t                     stat
);

	import iafp_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic              state_q;
	logic              state_nxt;
	logic [7:0]        store_q [FRAME_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        sum_q;
	logic [7:0]        start_q;
	logic [7:0]        type_q;
	logic              load;
	logic              drop;
	logic              emit;
	logic              sum_ok;

	// sum_q tracks the low byte of the sum of stored positions below CHECK_POS
	assign sum_ok = (store_q[CHECK_POS] == sum_q);

	always_comb begin
		state_nxt = state_q;
		load      = 1'b0;
		drop      = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					load      = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (fill_q != '0 && store_q[0] != start_q) begin
					drop = 1'b1;
				end else if (fill_q < FILL_W'(2)) begin
					state_nxt = ST_IDLE;
				end else if (store_q[1] == type_q) begin
					if (fill_q != FILL_W'(FRAME_BYTES)) begin
						state_nxt = ST_IDLE;
					end else if (sum_ok) begin
						// hold until the result queue has room
						if (!out_full) begin
							emit = 1'b1;
							drop = 1'b1;
						end
					end else begin
						drop = 1'b1;
					end
				end else begin
					drop = 1'b1;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign in_take  = load;
	assign out_push = emit;
	assign out_data.roll  = $signed({store_q[3], store_q[2]});
	assign out_data.pitch = $signed({store_q[5], store_q[4]});
	assign out_data.yaw   = $signed({store_q[7], store_q[6]});
	assign stat.busy = (state_q == ST_SCAN);
	assign stat.fill = fill_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (fill_q < FILL_W'(FRAME_BYTES)) begin
				store_q[fill_q] <= in_byte;
			end
		end else if (drop) begin
			for (int i = 0; i < FRAME_BYTES - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			sum_q   <= '0;
			start_q <= START_BYTE_RST;
			type_q  <= ATTITUDE_TYPE_RST;
		end else begin
			state_q <= state_nxt;
			if (load && fill_q < FILL_W'(FRAME_BYTES)) begin
				fill_q <= fill_q + 1'b1;
				if (fill_q < FILL_W'(CHECK_POS)) begin
					sum_q <= sum_q + in_byte;
				end
			end else if (drop) begin
				fill_q <= fill_q - 1'b1;
				// the checksum byte slides into the summed window on a full store
				sum_q  <= sum_q - store_q[0] +
					((fill_q == FILL_W'(FRAME_BYTES)) ? store_q[CHECK_POS] : 8'd0);
			end
			if (wr_en) begin
				unique case (wr_index)
					REG_START_BYTE:    start_q <= wr_data;
					REG_ATTITUDE_TYPE: type_q  <= wr_data;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/imu_attitude_frame_parser_unit.sv =====
// Attitude frame parser: byte queue -> frame scanner -> result queue.
// Path: the closing byte is registered in the byte queue, then in the frame store, and a result
// is then registered in the result queue. The scanner takes a new byte only when idle, once
// the scan of the last byte ends; a scan drops up to 11 bytes, shifting the store one byte per cycle.
// Reset: arst_n clears queues, fill count, checksum and state, and loads register
// defaults; the frame store contents are not cleared.
`default_nettype none

module imu_attitude_frame_parser_unit #(
	parameter int BYTE_QUEUE_DEPTH   = iafp_pkg::BYTE_QUEUE_DEF,
	parameter int RESULT_QUEUE_DEPTH = iafp_pkg::RESULT_QUEUE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [7:0]                        rx_byte,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic signed [15:0]                     roll_angle,
	output logic signed [15:0]                     pitch_angle,
	output logic signed [15:0]                     yaw_angle,
	input  wire logic                              wr_en,
	input  wire logic [iafp_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  wire logic [iafp_pkg::CFG_DATA_W-1:0]   wr_data
);

	import iafp_pkg::*;

	logic       byte_empty;
	logic [7:0] byte_data;
	logic       byte_take;
	logic       res_full;
	logic       res_push;
	result_t    res_in;
	result_t    res_out;
	scan_stat_t stat;

	iafp_fifo #(
		.WIDTH (8),
		.DEPTH (BYTE_QUEUE_DEPTH)
	) u_byte_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (rx_byte),
		.full    (full),
		.rd_en   (byte_take),
		.rd_data (byte_data),
		.empty   (byte_empty)
	);

	iafp_scanner u_scanner (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!byte_empty),
		.in_byte  (byte_data),
		.in_take  (byte_take),
		.out_full (res_full),
		.out_push (res_push),
		.out_data (res_in),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.stat     (stat)
	);

	iafp_fifo #(
		.WIDTH (RESULT_W),
		.DEPTH (RESULT_QUEUE_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign roll_angle  = res_out.roll;
	assign pitch_angle = res_out.pitch;
	assign yaw_angle   = res_out.yaw;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= FILL_W'(FRAME_BYTES))
		else $error("frame store fill beyond frame length");

	a_idle_room: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.busy |-> stat.fill < FILL_W'(FRAME_BYTES))
		else $error("scanner idle with a full frame store");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result request while result queue full");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		byte_take |-> !byte_empty && !stat.busy)
		else $error("byte request taken from empty queue or during scan");

endmodule

`default_nettype wire
